FILE: rtl/tpr_pkg.sv
// Shared constants, types and controller/datapath interface for the time-pair ring.
package tpr_pkg;

   // Ring depth is a power of two: slot arithmetic wraps in SLOT_W bits.
   localparam int RING_DEPTH    = 1024;
   localparam int SLOT_W        = $clog2(RING_DEPTH);
   localparam int HALF_WINDOW   = 5;
   localparam int WINDOW_SPAN   = 2 * HALF_WINDOW;
   localparam int CNT_W         = $clog2(WINDOW_SPAN + 1);
   localparam int OLDEST_OFFSET = 2;

   localparam int FUNC_W       = 2;
   localparam int SEC_W        = 32;
   localparam int NSEC_W       = 30;
   localparam int MATCH_SLOT_W = 10;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_RECORD    = 2'd0,
      FUNC_QUERY_UTC = 2'd1,
      FUNC_QUERY_RAW = 2'd2,
      FUNC_NOP       = 2'd3
   } func_type;

   typedef struct packed {
      logic [SEC_W-1:0]  raw_sec;
      logic [NSEC_W-1:0] raw_nsec;
      logic [SEC_W-1:0]  utc_sec;
   } rec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_NEWEST,
      ST_OLDEST,
      ST_CHECK,
      ST_WINDOW,
      ST_SCAN,
      ST_DRAIN,
      ST_RESPOND
   } state_type;

   typedef enum logic [1:0] {
      ADDR_NEWEST,
      ADDR_OLDEST,
      ADDR_SCAN
   } addr_sel_type;

   typedef struct packed {
      logic         load;
      logic         write;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         cap_newest;
      logic         check;
      logic         window;
      logic         scan;
      logic         emit;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic scan_last;
   } status_type;

endpackage

FILE: rtl/time_pair_ring_lookup.sv
// Top level of the time-pair ring: record store with windowed nearest-key lookup.
//
//  channel   ports                                  handshake
//  request   req_func req_raw_sec req_raw_nsec      start & !busy transfers one item
//            req_utc_sec
//  response  rsp_matched rsp_match_slot             rsp_strobe, one cycle, no backpressure
//            rsp_out_raw_sec rsp_out_raw_nsec
//            rsp_out_utc_sec
//
// A record holds busy through its WRITE state, so the next request waits for it; a no-op
// func is taken in its accept cycle.
// A query reads newest, oldest and then the search window from the single read port
// of the record memory one slot a cycle; the window length is at least 1 and at most
// 2 * HALF_WINDOW, and an out-of-range key skips the window scan and answers without
// it. Busy drops as the strobe rises.
// Reset is synchronous and needs no clearing pass: the write pointer and wrap flag
// mark which slots hold data, and unwritten slots read as zero.
module time_pair_ring_lookup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tpr_pkg::FUNC_W-1:0]        req_func,
   input  logic [tpr_pkg::SEC_W-1:0]         req_raw_sec,
   input  logic [tpr_pkg::NSEC_W-1:0]        req_raw_nsec,
   input  logic [tpr_pkg::SEC_W-1:0]         req_utc_sec,
   output logic                              rsp_strobe,
   output logic                              rsp_matched,
   output logic [tpr_pkg::MATCH_SLOT_W-1:0]  rsp_match_slot,
   output logic [tpr_pkg::SEC_W-1:0]         rsp_out_raw_sec,
   output logic [tpr_pkg::NSEC_W-1:0]        rsp_out_raw_nsec,
   output logic [tpr_pkg::SEC_W-1:0]         rsp_out_utc_sec
);

   tpr_pkg::cmd_type    cmd;
   tpr_pkg::status_type status;

   tpr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   tpr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_raw_sec      (req_raw_sec),
      .req_raw_nsec     (req_raw_nsec),
      .req_utc_sec      (req_utc_sec),
      .rsp_strobe       (rsp_strobe),
      .rsp_matched      (rsp_matched),
      .rsp_match_slot   (rsp_match_slot),
      .rsp_out_raw_sec  (rsp_out_raw_sec),
      .rsp_out_raw_nsec (rsp_out_raw_nsec),
      .rsp_out_utc_sec  (rsp_out_utc_sec)
   );

endmodule

FILE: rtl/tpr_ctrl.sv
// Sequencer for record writes and windowed nearest-key queries.
module tpr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tpr_pkg::FUNC_W-1:0]  req_func,
   input  tpr_pkg::status_type         status,
   output tpr_pkg::cmd_type            cmd,
   output logic                        busy
);

   tpr_pkg::state_type state_ff;
   tpr_pkg::state_type state_in;
   tpr_pkg::func_type  func;

   assign func = tpr_pkg::func_type'(req_func);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpr_pkg::ST_IDLE: begin
            if (start) begin
               case (func)
                  tpr_pkg::FUNC_RECORD:    state_in = tpr_pkg::ST_WRITE;
                  tpr_pkg::FUNC_QUERY_UTC: state_in = tpr_pkg::ST_NEWEST;
                  tpr_pkg::FUNC_QUERY_RAW: state_in = tpr_pkg::ST_NEWEST;
                  default:                 state_in = tpr_pkg::ST_IDLE;
               endcase
            end
         end
         tpr_pkg::ST_WRITE:  state_in = tpr_pkg::ST_IDLE;
         tpr_pkg::ST_NEWEST: state_in = tpr_pkg::ST_OLDEST;
         tpr_pkg::ST_OLDEST: state_in = tpr_pkg::ST_CHECK;
         tpr_pkg::ST_CHECK:  state_in = tpr_pkg::ST_WINDOW;
         tpr_pkg::ST_WINDOW: begin
            state_in = status.in_range ? tpr_pkg::ST_SCAN : tpr_pkg::ST_RESPOND;
         end
         tpr_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = tpr_pkg::ST_DRAIN;
            end
         end
         tpr_pkg::ST_DRAIN:   state_in = tpr_pkg::ST_RESPOND;
         tpr_pkg::ST_RESPOND: state_in = tpr_pkg::ST_IDLE;
         default:             state_in = tpr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.addr_sel = tpr_pkg::ADDR_NEWEST;
      case (state_ff)
         tpr_pkg::ST_IDLE:   cmd.load = start;
         tpr_pkg::ST_WRITE:  cmd.write = 1'b1;
         tpr_pkg::ST_NEWEST: cmd.rd_en = 1'b1;
         tpr_pkg::ST_OLDEST: begin
            cmd.rd_en      = 1'b1;
            cmd.addr_sel   = tpr_pkg::ADDR_OLDEST;
            cmd.cap_newest = 1'b1;
         end
         tpr_pkg::ST_CHECK:  cmd.check = 1'b1;
         tpr_pkg::ST_WINDOW: cmd.window = 1'b1;
         tpr_pkg::ST_SCAN: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = tpr_pkg::ADDR_SCAN;
            cmd.scan     = 1'b1;
         end
         tpr_pkg::ST_RESPOND: cmd.emit = 1'b1;
         default:             cmd.load = 1'b0;
      endcase
   end

   assign busy = (state_ff != tpr_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/tpr_dp.sv
// Datapath: record store, range check, window setup and nearest-key scan.
module tpr_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  tpr_pkg::cmd_type                  cmd,
   output tpr_pkg::status_type               status,
   input  logic [tpr_pkg::FUNC_W-1:0]        req_func,
   input  logic [tpr_pkg::SEC_W-1:0]         req_raw_sec,
   input  logic [tpr_pkg::NSEC_W-1:0]        req_raw_nsec,
   input  logic [tpr_pkg::SEC_W-1:0]         req_utc_sec,
   output logic                              rsp_strobe,
   output logic                              rsp_matched,
   output logic [tpr_pkg::MATCH_SLOT_W-1:0]  rsp_match_slot,
   output logic [tpr_pkg::SEC_W-1:0]         rsp_out_raw_sec,
   output logic [tpr_pkg::NSEC_W-1:0]        rsp_out_raw_nsec,
   output logic [tpr_pkg::SEC_W-1:0]         rsp_out_utc_sec
);

   localparam int SW = tpr_pkg::SLOT_W;
   localparam int CW = tpr_pkg::CNT_W;

   tpr_pkg::rec_type store_ff [tpr_pkg::RING_DEPTH];

   tpr_pkg::rec_type             wr_rec_ff;
   logic [tpr_pkg::SEC_W-1:0]    key_ff;
   logic                         query_utc_ff;
   logic [SW-1:0]                write_slot_ff, write_slot_in;
   logic                         wrapped_ff, wrapped_in;

   logic [SW-1:0]                rd_addr;
   tpr_pkg::rec_type             mem_q_ff;
   logic                         rd_ok_ff;
   logic [SW-1:0]                rd_slot_ff;
   logic                         scan_rd_ff;
   tpr_pkg::rec_type             rd_rec;
   logic [tpr_pkg::SEC_W-1:0]    rd_key;

   logic [tpr_pkg::SEC_W-1:0]    newest_ff;
   logic                         in_range_ff, in_range_in;
   logic [SW-1:0]                pred_ff, pred_in;
   logic [tpr_pkg::SEC_W-1:0]    back;

   logic [SW-1:0]                win_start, win_end, win_start_fix, win_len;
   logic [SW-1:0]                scan_slot_ff;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         first_ff;

   logic [tpr_pkg::SEC_W-1:0]    diff;
   logic                         take;
   logic [tpr_pkg::SEC_W-1:0]    best_diff_ff;
   logic [SW-1:0]                best_slot_ff;
   tpr_pkg::rec_type             best_rec_ff;

   logic                         rsp_strobe_ff;
   logic                         rsp_matched_ff;
   logic [tpr_pkg::MATCH_SLOT_W-1:0] rsp_match_slot_ff;
   tpr_pkg::rec_type             rsp_rec_ff;

   // Input latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wr_rec_ff.raw_sec  <= req_raw_sec;
         wr_rec_ff.raw_nsec <= req_raw_nsec;
         wr_rec_ff.utc_sec  <= req_utc_sec;
         query_utc_ff <= (tpr_pkg::func_type'(req_func) == tpr_pkg::FUNC_QUERY_UTC);
         key_ff <= (tpr_pkg::func_type'(req_func) == tpr_pkg::FUNC_QUERY_UTC) ?
                   req_utc_sec : req_raw_sec;
      end
   end

   // Write pointer and wrap flag
   always_comb begin
      write_slot_in = write_slot_ff;
      wrapped_in    = wrapped_ff;
      if (cmd.write) begin
         write_slot_in = write_slot_ff + SW'(1);
         if (write_slot_in == '0) begin
            wrapped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         wrapped_ff    <= 1'b0;
      end else begin
         write_slot_ff <= write_slot_in;
         wrapped_ff    <= wrapped_in;
      end
   end

   // Read address select
   always_comb begin
      case (cmd.addr_sel)
         tpr_pkg::ADDR_NEWEST: rd_addr = write_slot_ff - SW'(1);
         tpr_pkg::ADDR_OLDEST: begin
            rd_addr = wrapped_ff ? (write_slot_ff + SW'(tpr_pkg::OLDEST_OFFSET)) : '0;
         end
         tpr_pkg::ADDR_SCAN:   rd_addr = scan_slot_ff;
         default:              rd_addr = '0;
      endcase
   end

   // Record store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         store_ff[write_slot_ff] <= wr_rec_ff;
      end
      if (cmd.rd_en) begin
         mem_q_ff   <= store_ff[rd_addr];
         // Slots never written since reset read as zero
         rd_ok_ff   <= wrapped_ff || (rd_addr < write_slot_ff);
         rd_slot_ff <= rd_addr;
      end
   end

   assign rd_rec = rd_ok_ff ? mem_q_ff : '0;
   assign rd_key = query_utc_ff ? rd_rec.utc_sec : rd_rec.raw_sec;

   // Range check and predicted slot
   assign back        = newest_ff - key_ff;
   assign in_range_in = !(key_ff < rd_key) && !(key_ff > newest_ff);
   assign pred_in     = write_slot_ff - back[SW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.cap_newest) begin
         newest_ff <= rd_key;
      end
      if (cmd.check) begin
         in_range_ff <= in_range_in;
         pred_ff     <= pred_in;
      end
   end

   // Window bounds; before the first wrap a window running below slot 0 starts at 0
   assign win_start     = pred_ff - SW'(tpr_pkg::HALF_WINDOW);
   assign win_end       = pred_ff + SW'(tpr_pkg::HALF_WINDOW);
   assign win_start_fix = ((win_start > win_end) && !wrapped_ff) ? '0 : win_start;
   assign win_len       = win_end - win_start_fix;

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.window) begin
         // An empty window still reads its start slot
         cnt_in = (win_len == '0) ? CW'(1) : win_len[CW-1:0];
      end else if (cmd.scan) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         scan_rd_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         scan_rd_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.window) begin
         scan_slot_ff <= win_start_fix;
      end else if (cmd.scan) begin
         scan_slot_ff <= scan_slot_ff + SW'(1);
      end
   end

   assign status.in_range  = in_range_ff;
   assign status.scan_last = (cnt_ff == CW'(1));

   // Compare stage: strictly smaller difference replaces, so the first entry wins ties
   assign diff = (key_ff >= rd_key) ? (key_ff - rd_key) : (rd_key - key_ff);
   assign take = scan_rd_ff && (first_ff || (diff < best_diff_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
      end else if (cmd.window) begin
         first_ff <= 1'b1;
      end else if (scan_rd_ff) begin
         first_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_diff_ff <= diff;
         best_slot_ff <= rd_slot_ff;
         best_rec_ff  <= rd_rec;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_matched_ff    <= in_range_ff;
         rsp_match_slot_ff <= in_range_ff ? tpr_pkg::MATCH_SLOT_W'(best_slot_ff) : '0;
         rsp_rec_ff        <= in_range_ff ? best_rec_ff : '0;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_matched      = rsp_matched_ff;
   assign rsp_match_slot   = rsp_match_slot_ff;
   assign rsp_out_raw_sec  = rsp_rec_ff.raw_sec;
   assign rsp_out_raw_nsec = rsp_rec_ff.raw_nsec;
   assign rsp_out_utc_sec  = rsp_rec_ff.utc_sec;

`ifndef SYNTHESIS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_matched_ff |->
         rsp_match_slot_ff == '0 && rsp_rec_ff == '0)
      else $error("unmatched result carries nonzero fields");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      wrapped_ff |=> wrapped_ff)
      else $error("wrap flag cleared without reset");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> cnt_ff != '0)
      else $error("scan issued with exhausted count");

   a_hit_scanned: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && in_range_ff |-> !first_ff)
      else $error("matched result emitted before any entry was compared");
`endif

endmodule
